[rtl/time_bin_weighted_average_defines.svh]
// Assertion macros used by the RTL controller.
`ifndef TIME_BIN_WEIGHTED_AVERAGE_DEFINES_SVH
`define TIME_BIN_WEIGHTED_AVERAGE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TBWA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TBWA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tbwa_pkg.sv]
package tbwa_pkg;

    localparam int MaxPoints   = 4096;
    localparam int CountW      = 13;
    localparam int WeightShift = 20;
    localparam int WeightW     = WeightShift + 1;
    localparam int NumW        = 64;
    localparam int DenW        = 40;
    localparam int RootW       = 32;
    localparam int CntDivW     = 7;
    localparam int CntSqrtW    = 6;

    localparam logic [1:0] CfgBinWidth = 2'd0;
    localparam logic [1:0] CfgDefError = 2'd1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK, ST_OPEN, ST_SQ, ST_WDIV, ST_WWAIT, ST_MUL, ST_ACC,
        ST_POINT, ST_MDIV, ST_MWAIT, ST_NSQ, ST_NCUBE, ST_NKEEP, ST_ESQ,
        ST_EDIV, ST_EWAIT, ST_SQRT, ST_SWAIT, ST_OUT, ST_CLEAR
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_OPEN, OP_MUL, OP_ACC, OP_DIV_START, OP_DIV_TAKE,
        OP_SQRT_START, OP_SQRT_TAKE, OP_POINT, OP_EMIT, OP_CLEAR
    } t_dp_op;

    typedef enum logic [3:0] {
        SEL_ERR2, SEL_WEIGHT, SEL_OFF, SEL_MAG, SEL_X, SEL_Y, SEL_AP,
        SEL_N2, SEL_N3, SEL_ES2, SEL_ERR
    } t_sel;

    typedef struct packed {
        t_dp_op op;
        t_sel   sel;
        logic   final_bin;
    } t_dp_cmd;

    typedef struct packed {
        logic close;
        logic eos;
        logic out_free;
        logic div_done;
        logic sqrt_done;
    } t_dp_stat;

    // Channel order of the five weighted means.
    function automatic t_sel ch_sel(input logic [2:0] idx);
        t_sel s;
        case (idx)
            3'd0:    s = SEL_OFF;
            3'd1:    s = SEL_MAG;
            3'd2:    s = SEL_X;
            3'd3:    s = SEL_Y;
            default: s = SEL_AP;
        endcase
        return s;
    endfunction

endpackage

[rtl/tbwa_div.sv]
module tbwa_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tbwa_pkg::NumW-1:0]  i_num,
    input  logic [tbwa_pkg::DenW-1:0]  i_den,
    output logic                       o_busy,
    output logic [tbwa_pkg::NumW-1:0]  o_quo
);
    import tbwa_pkg::*;

    logic [NumW-1:0]    r_quo;
    logic [DenW:0]      r_rem;
    logic [DenW-1:0]    r_den;
    logic [CntDivW-1:0] r_cnt;
    logic               r_busy;
    logic [DenW:0]      rem_sh;
    logic               fits;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        rem_sh = {r_rem[DenW-1:0], r_quo[NumW-1]};
        fits   = rem_sh >= {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CntDivW'(NumW);
            r_quo  <= i_num;
            r_rem  <= '0;
            r_den  <= i_den;
        end else if (r_busy) begin
            r_rem  <= fits ? rem_sh - {1'b0, r_den} : rem_sh;
            r_quo  <= {r_quo[NumW-2:0], fits};
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == CntDivW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
endmodule

[rtl/tbwa_sqrt.sv]
module tbwa_sqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [tbwa_pkg::NumW-1:0]  i_rad,
    output logic                       o_busy,
    output logic [tbwa_pkg::RootW-1:0] o_root
);
    import tbwa_pkg::*;

    logic [NumW-1:0]     r_rad;
    logic [RootW+2:0]    r_rem;
    logic [RootW-1:0]    r_root;
    logic [CntSqrtW-1:0] r_cnt;
    logic                r_busy;
    logic [RootW+2:0]    rem_sh;
    logic [RootW+2:0]    trial;
    logic                fits;

    // Digit-by-digit root, two radicand bits per cycle.
    always_comb begin
        rem_sh = {r_rem[RootW:0], r_rad[NumW-1:NumW-2]};
        trial  = {1'b0, r_root, 2'b01};
        fits   = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CntSqrtW'(RootW);
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[NumW-3:0], 2'b00};
            r_rem  <= fits ? rem_sh - trial : rem_sh;
            r_root <= {r_root[RootW-2:0], fits};
            r_cnt  <= r_cnt - 1'b1;
            if (r_cnt == CntSqrtW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;
endmodule

[rtl/tbwa_datapath.sv]
module tbwa_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tbwa_pkg::t_dp_cmd  i_cmd,
    output tbwa_pkg::t_dp_stat o_stat,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [26:0]        i_cfg_data,
    input  logic [135:0]       i_in_data,
    input  logic               i_in_last,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [151:0]       o_out_data,
    output logic               o_out_last
);
    import tbwa_pkg::*;

    logic [26:0]        r_bin_width;
    logic [15:0]        r_def_err;

    logic [47:0]        r_t;
    logic [19:0]        r_mag;
    logic [15:0]        r_err;
    logic [17:0]        r_x;
    logic [17:0]        r_y;
    logic [15:0]        r_ap;
    logic               r_eos;

    logic               r_open;
    logic [47:0]        r_start;
    logic [CountW-1:0]  r_count;
    logic [32:0]        r_wsum;
    logic [59:0]        r_sum_off;
    logic [52:0]        r_sum_mag;
    logic [50:0]        r_sum_x;
    logic [50:0]        r_sum_y;
    logic [48:0]        r_sum_ap;
    logic [27:0]        r_err_sum;
    logic               r_invalid;

    logic [WeightW-1:0] r_w;
    logic [63:0]        r_prod;
    logic [36:0]        r_n3;
    logic [47:0]        r_q_off;
    logic [19:0]        r_q_mag;
    logic [17:0]        r_q_x;
    logic [17:0]        r_q_y;
    logic [15:0]        r_q_ap;
    logic [57:0]        r_m;
    logic [RootW-1:0]   r_root;

    logic               r_out_valid;
    logic [151:0]       r_out_data;
    logic               r_out_last;

    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [26:0]        offset;
    logic [48:0]        limit;
    logic               out_free;
    logic [NumW-1:0]    div_num;
    logic [DenW-1:0]    div_den;
    logic [NumW-1:0]    div_quo;
    logic               div_busy;
    logic [RootW-1:0]   sqrt_root;
    logic               sqrt_busy;
    logic [33:0]        wden;
    logic [RootW-1:0]   half_root;
    logic [15:0]        err_val;

    tbwa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_DIV_START),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quo   (div_quo)
    );

    tbwa_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_SQRT_START),
        .i_rad   ({6'd0, r_m}),
        .o_busy  (sqrt_busy),
        .o_root  (sqrt_root)
    );

    always_comb begin
        limit    = {1'b0, r_start} + {22'd0, r_bin_width};
        // Points before the bin start count at the start.
        offset   = (r_t > r_start) ? 27'(r_t - r_start) : '0;
        out_free = !r_out_valid || i_out_ready;
        wden     = {r_wsum, 1'b0};
        o_stat.close     = r_open && (({1'b0, r_t} > limit) || r_count[CountW-1]);
        o_stat.eos       = r_eos;
        o_stat.out_free  = out_free;
        o_stat.div_done  = !div_busy;
        o_stat.sqrt_done = !sqrt_busy;
    end

    always_comb begin
        mul_a = '0;
        mul_b = 32'(r_w);
        unique case (i_cmd.sel)
            SEL_ERR2: begin
                mul_a = 32'(r_err);
                mul_b = 32'(r_err);
            end
            SEL_OFF: mul_a = 32'(offset);
            SEL_MAG: mul_a = 32'({~r_mag[19], r_mag[18:0]});
            SEL_X:   mul_a = 32'(r_x);
            SEL_Y:   mul_a = 32'(r_y);
            SEL_AP:  mul_a = 32'(r_ap);
            SEL_N2: begin
                mul_a = 32'(r_count);
                mul_b = 32'(r_count);
            end
            SEL_N3: begin
                mul_a = 32'(r_prod[25:0]);
                mul_b = 32'(r_count);
            end
            SEL_ES2: begin
                mul_a = 32'(r_err_sum);
                mul_b = 32'(r_err_sum);
            end
            default: mul_a = '0;
        endcase
    end

    always_comb begin
        div_den = DenW'(wden);
        div_num = '0;
        unique case (i_cmd.sel)
            SEL_WEIGHT: begin
                div_num = NumW'(1) << WeightShift;
                div_den = DenW'(r_prod[31:0]);
            end
            SEL_OFF: div_num = NumW'({r_sum_off, 1'b0}) + NumW'(r_wsum);
            SEL_MAG: div_num = NumW'({r_sum_mag, 1'b0}) + NumW'(r_wsum);
            SEL_X:   div_num = NumW'({r_sum_x, 1'b0}) + NumW'(r_wsum);
            SEL_Y:   div_num = NumW'({r_sum_y, 1'b0}) + NumW'(r_wsum);
            SEL_AP:  div_num = NumW'({r_sum_ap, 1'b0}) + NumW'(r_wsum);
            SEL_ERR: begin
                div_num = NumW'({r_prod[55:0], 2'b00});
                div_den = DenW'(r_n3);
            end
            default: div_num = '0;
        endcase
    end

    always_comb begin
        half_root = RootW'(({1'b0, r_root} + 1'b1) >> 1);
        if ((r_count > CountW'(1)) && r_invalid) begin
            err_val = r_def_err;
        end else if (half_root > RootW'(16'hFFFF)) begin
            err_val = 16'hFFFF;
        end else begin
            err_val = half_root[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_width <= 27'd600;
            r_def_err   <= 16'd200;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgBinWidth: r_bin_width <= i_cfg_data;
                CfgDefError: r_def_err   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD) begin
            r_t   <= i_in_data[47:0];
            r_mag <= i_in_data[67:48];
            r_err <= i_in_data[83:68];
            r_x   <= i_in_data[101:84];
            r_y   <= i_in_data[119:102];
            r_ap  <= i_in_data[135:120];
            r_eos <= i_in_last;
        end
        if (i_cmd.op == OP_MUL) begin
            r_prod <= mul_a * mul_b;
        end
        if (i_cmd.op == OP_DIV_TAKE) begin
            unique case (i_cmd.sel)
                SEL_WEIGHT: begin
                    if (r_err == '0) begin
                        r_w <= WeightW'(1) << WeightShift;
                    end else if (div_quo == '0) begin
                        r_w <= WeightW'(1);
                    end else begin
                        r_w <= div_quo[WeightW-1:0];
                    end
                end
                SEL_OFF: r_q_off <= div_quo[47:0];
                SEL_MAG: r_q_mag <= div_quo[19:0];
                SEL_X:   r_q_x   <= div_quo[17:0];
                SEL_Y:   r_q_y   <= div_quo[17:0];
                SEL_AP:  r_q_ap  <= div_quo[15:0];
                SEL_ERR: r_m     <= div_quo[57:0];
                default: ;
            endcase
        end
        if (i_cmd.op == OP_SQRT_TAKE) begin
            r_root <= sqrt_root;
        end
        if ((i_cmd.op == OP_ACC) && (i_cmd.sel == SEL_N3)) begin
            r_n3 <= r_prod[36:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_cmd.op == OP_CLEAR)) begin
            r_open    <= 1'b0;
            r_start   <= '0;
            r_count   <= '0;
            r_wsum    <= '0;
            r_sum_off <= '0;
            r_sum_mag <= '0;
            r_sum_x   <= '0;
            r_sum_y   <= '0;
            r_sum_ap  <= '0;
            r_err_sum <= '0;
            r_invalid <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_OPEN: begin
                    if (!r_open) begin
                        r_open  <= 1'b1;
                        r_start <= r_t;
                    end
                end
                OP_ACC: begin
                    unique case (i_cmd.sel)
                        SEL_OFF: r_sum_off <= r_sum_off + r_prod[59:0];
                        SEL_MAG: r_sum_mag <= r_sum_mag + r_prod[52:0];
                        SEL_X:   r_sum_x   <= r_sum_x + r_prod[50:0];
                        SEL_Y:   r_sum_y   <= r_sum_y + r_prod[50:0];
                        SEL_AP:  r_sum_ap  <= r_sum_ap + r_prod[48:0];
                        default: ;
                    endcase
                end
                OP_POINT: begin
                    r_count   <= r_count + 1'b1;
                    r_wsum    <= r_wsum + 33'(r_w);
                    r_err_sum <= r_err_sum + 28'(r_err);
                    if (r_err == '0) begin
                        r_invalid <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Output register: holds a finished bin until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.op == OP_EMIT) begin
            r_out_last <= i_cmd.final_bin;
            r_out_data <= {3'd0, r_count, r_q_ap, r_q_y, r_q_x, err_val,
                           {~r_q_mag[19], r_q_mag[18:0]}, r_start + r_q_off};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;
endmodule

[rtl/tbwa_ctrl.sv]
`include "time_bin_weighted_average_defines.svh"

module tbwa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tbwa_pkg::t_dp_stat i_stat,
    output tbwa_pkg::t_dp_cmd  o_cmd
);
    import tbwa_pkg::*;

    t_state     r_state;
    t_state     n_state;
    logic [2:0] r_idx;
    logic [2:0] n_idx;
    logic       r_final;
    logic       n_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
            r_final <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_final <= n_final;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_idx           = r_idx;
        n_final         = r_final;
        o_cmd.op        = OP_NONE;
        o_cmd.sel       = ch_sel(r_idx);
        o_cmd.final_bin = r_final;
        o_in_ready      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_idx = '0;
                if (i_stat.close) begin
                    n_final = 1'b0;
                    n_state = ST_MDIV;
                end else begin
                    n_state = ST_OPEN;
                end
            end
            ST_OPEN: begin
                o_cmd.op = OP_OPEN;
                n_state  = ST_SQ;
            end
            ST_SQ: begin
                o_cmd.op  = OP_MUL;
                o_cmd.sel = SEL_ERR2;
                n_state   = ST_WDIV;
            end
            ST_WDIV: begin
                o_cmd.op  = OP_DIV_START;
                o_cmd.sel = SEL_WEIGHT;
                n_state   = ST_WWAIT;
            end
            ST_WWAIT: begin
                o_cmd.sel = SEL_WEIGHT;
                if (i_stat.div_done) begin
                    o_cmd.op = OP_DIV_TAKE;
                    n_idx    = '0;
                    n_state  = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.op = OP_MUL;
                n_state  = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.op = OP_ACC;
                if (r_idx == 3'd4) begin
                    n_state = ST_POINT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = ST_MUL;
                end
            end
            ST_POINT: begin
                o_cmd.op = OP_POINT;
                if (i_stat.eos) begin
                    n_final = 1'b1;
                    n_idx   = '0;
                    n_state = ST_MDIV;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_MDIV: begin
                o_cmd.op = OP_DIV_START;
                n_state  = ST_MWAIT;
            end
            ST_MWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.op = OP_DIV_TAKE;
                    if (r_idx == 3'd4) begin
                        n_state = ST_NSQ;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_MDIV;
                    end
                end
            end
            ST_NSQ: begin
                o_cmd.op  = OP_MUL;
                o_cmd.sel = SEL_N2;
                n_state   = ST_NCUBE;
            end
            ST_NCUBE: begin
                o_cmd.op  = OP_MUL;
                o_cmd.sel = SEL_N3;
                n_state   = ST_NKEEP;
            end
            ST_NKEEP: begin
                o_cmd.op  = OP_ACC;
                o_cmd.sel = SEL_N3;
                n_state   = ST_ESQ;
            end
            ST_ESQ: begin
                o_cmd.op  = OP_MUL;
                o_cmd.sel = SEL_ES2;
                n_state   = ST_EDIV;
            end
            ST_EDIV: begin
                o_cmd.op  = OP_DIV_START;
                o_cmd.sel = SEL_ERR;
                n_state   = ST_EWAIT;
            end
            ST_EWAIT: begin
                o_cmd.sel = SEL_ERR;
                if (i_stat.div_done) begin
                    o_cmd.op = OP_DIV_TAKE;
                    n_state  = ST_SQRT;
                end
            end
            ST_SQRT: begin
                o_cmd.op = OP_SQRT_START;
                n_state  = ST_SWAIT;
            end
            ST_SWAIT: begin
                if (i_stat.sqrt_done) begin
                    o_cmd.op = OP_SQRT_TAKE;
                    n_state  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                // A closed bin hands over to the point that closed it.
                n_state  = r_final ? ST_IDLE : ST_OPEN;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    `TBWA_ASSERT_NOW(a_div_idle, i_clk, i_rst_n, o_cmd.op == OP_DIV_START, i_stat.div_done, "divider restarted while busy")
    `TBWA_ASSERT_NOW(a_emit_free, i_clk, i_rst_n, o_cmd.op == OP_EMIT, i_stat.out_free, "bin emitted over a pending result")
    `TBWA_ASSERT_NEXT(a_eos_final, i_clk, i_rst_n, (r_state == ST_POINT) && i_stat.eos, r_final && (r_state == ST_MDIV), "end of series did not start a final bin")
    `TBWA_ASSERT_NEXT(a_close_reopen, i_clk, i_rst_n, (r_state == ST_CLEAR) && !r_final, r_state == ST_OPEN, "closing point was dropped")
endmodule

[rtl/time_bin_weighted_average.sv]
// Bins a time-sorted photometry stream and emits one inverse-variance weighted
// average per bin. A point is accepted only while the block is idle; a point
// that joins the open bin spends most of its time in the one-bit-per-cycle
// divider that forms its weight. A point that closes a bin, or ends the series,
// adds six divider passes (five means and the error ratio), a square root and a
// few multiply steps, plus any wait for the previous bin to leave the output
// register. A point that both closes a bin and ends the series produces two
// bins, the closed one first. tlast on input marks end of series; on output it
// marks the final bin.
module time_bin_weighted_average (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [26:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // sample_time[47:0], magnitude[67:48], mag_error[83:68], x_pos[101:84],
    // y_pos[119:102], aperture[135:120]
    input  logic [135:0] s_axis_tdata,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // bin_time[47:0], bin_magnitude[67:48], bin_error[83:68], bin_x[101:84],
    // bin_y[119:102], bin_aperture[135:120], points_in_bin[148:136], zeros above
    output logic [151:0] m_axis_tdata,
    output logic         m_axis_tlast
);
    import tbwa_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    tbwa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tbwa_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_in_last   (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );
endmodule

[bench/tb_time_bin_weighted_average.sv]
module tb_time_bin_weighted_average;
    timeunit 1ns;
    timeprecision 1ps;

    import tbwa_pkg::*;

    // index past the last register, must be ignored
    localparam logic [1:0] CfgNone = 2'd3;

    typedef struct packed {
        logic [47:0] t;
        logic [19:0] mag;
        logic [15:0] err;
        logic [17:0] x;
        logic [17:0] y;
        logic [15:0] ap;
        logic        eos;
    } t_point;

    typedef struct packed {
        logic [47:0] t;
        logic [19:0] mag;
        logic [15:0] err;
        logic [17:0] x;
        logic [17:0] y;
        logic [15:0] ap;
        logic [12:0] n;
        logic        fin;
    } t_bin;

    // directed row: point, plus an optional typed-in bin for the closing output
    typedef struct {
        t_point p;
        logic   has_bin;
        t_bin   b;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_index;
    logic [26:0]  i_cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // sample_time, magnitude, mag_error, x_pos, y_pos, aperture
    logic [135:0] s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // bin_time, bin_magnitude, bin_error, bin_x, bin_y, bin_aperture, points_in_bin
    logic [151:0] m_axis_tdata;
    logic         m_axis_tlast;

    time_bin_weighted_average dut (.*);

    // predictor state
    logic [26:0]  width_q;
    logic [15:0]  deferr_q;
    logic         open_q;
    logic [47:0]  start_q;
    logic [12:0]  cnt_q;
    logic [63:0]  wsum_q, offsum_q, xsum_q, ysum_q, apsum_q, esum_q;
    logic signed [63:0] magsum_q;
    logic         inval_q;

    t_bin   bins_due[$];
    int     errors = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     hold_off = 0;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [63:0] rnd_div(input logic [63:0] num, input logic [63:0] den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic void clear_bin();
        open_q = 0; start_q = 0; cnt_q = 0; wsum_q = 0; offsum_q = 0; magsum_q = 0;
        xsum_q = 0; ysum_q = 0; apsum_q = 0; esum_q = 0; inval_q = 0;
    endfunction

    function automatic t_bin close_bin(input logic fin);
        t_bin b;
        logic [63:0] w, magu, n3, m, r;
        w = wsum_q;
        magu = 64'(magsum_q) + 64'd524288 * w;
        b.t   = start_q + 48'(rnd_div(offsum_q, w));
        b.mag = 20'(rnd_div(magu, w) - 64'd524288);
        if (cnt_q > 1 && inval_q) begin
            b.err = deferr_q;
        end else begin
            n3 = 64'(cnt_q) * cnt_q * cnt_q;
            m = (4 * esum_q * esum_q) / n3;
            r = (int_sqrt(m) + 1) / 2;
            b.err = (r > 64'hFFFF) ? 16'hFFFF : 16'(r);
        end
        b.x   = 18'(rnd_div(xsum_q, w));
        b.y   = 18'(rnd_div(ysum_q, w));
        b.ap  = 16'(rnd_div(apsum_q, w));
        b.n   = cnt_q;
        b.fin = fin;
        return b;
    endfunction

    function automatic void predict_point(input t_point p);
        logic [63:0] w, off;
        if (open_q && (64'(p.t) > 64'(start_q) + width_q || cnt_q >= MaxPoints)) begin
            bins_due.push_back(close_bin(1'b0));
            clear_bin();
        end
        if (!open_q) begin
            open_q = 1;
            start_q = p.t;
        end
        if (p.err == 0) begin
            w = 64'd1 << WeightShift;
            inval_q = 1;
        end else begin
            w = (64'd1 << WeightShift) / (64'(p.err) * p.err);
            if (w == 0) w = 1;
        end
        off = (p.t > start_q) ? 64'(p.t - start_q) : 0;
        cnt_q++;
        wsum_q += w;
        offsum_q += off * w;
        magsum_q += 64'(signed'(p.mag)) * signed'(w);
        xsum_q += 64'(p.x) * w;
        ysum_q += 64'(p.y) * w;
        apsum_q += 64'(p.ap) * w;
        esum_q += p.err;
        if (p.eos) begin
            bins_due.push_back(close_bin(1'b1));
            clear_bin();
        end
    endfunction

    // tvalid stays up after a transaction; idling or drain() drops it
    task automatic send_point(input t_point p);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= {p.ap, p.y, p.x, p.err, p.mag, p.t};
        s_axis_tlast  <= p.eos;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_point(p);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [26:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == CfgBinWidth) width_q = val;
        else if (idx == CfgDefError) deferr_q = val[15:0];
        @(posedge i_clk);
    endtask

    // wait for outstanding bins, then for an unfinished bin to settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (bins_due.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    function automatic t_point rand_point(input logic [47:0] t, input int eos_pct);
        t_point p;
        p.t   = t;
        p.mag = 20'($urandom);
        case ($urandom_range(3))
            0: p.err = 16'($urandom);
            1: p.err = 16'($urandom_range(40, 1));
            2: p.err = 16'($urandom_range(2000, 1));
            default: p.err = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(300, 1));
        endcase
        p.x   = 18'($urandom);
        p.y   = 18'($urandom);
        p.ap  = 16'($urandom);
        p.eos = ($urandom_range(99) < eos_pct);
        return p;
    endfunction

    // output side: ready generation and checking
    always @(posedge i_clk) begin
        t_bin got, want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.t   = m_axis_tdata[47:0];
                got.mag = m_axis_tdata[67:48];
                got.err = m_axis_tdata[83:68];
                got.x   = m_axis_tdata[101:84];
                got.y   = m_axis_tdata[119:102];
                got.ap  = m_axis_tdata[135:120];
                got.n   = m_axis_tdata[148:136];
                got.fin = m_axis_tlast;
                if (bins_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected bin %p", $time, got);
                end else begin
                    want = bins_due.pop_front();
                    if (got !== want || m_axis_tdata[151:149] !== 3'b0) begin
                        errors++;
                        $display("%0t: bin mismatch expected %p actual %p", $time, want, got);
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
            end
        end
    end

    initial begin
        #400ms;
        $display("FAIL time_bin_weighted_average");
        $finish;
    end

    initial begin
        t_row rows[$];
        t_row r;
        t_point p;
        logic [47:0] t;
        int phase, k;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        width_q = 27'd600;
        deferr_q = 16'd200;
        clear_bin();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes with a typed-in bin, special cases through the predictor
        r.has_bin = 1;
        r.p = '{48'hFFFF_FFFF_FFFF, 20'h80000, 16'd1, 18'h3FFFF, 18'h3FFFF, 16'hFFFF, 1'b1};
        r.b = '{48'hFFFF_FFFF_FFFF, 20'h80000, 16'd1, 18'h3FFFF, 18'h3FFFF, 16'hFFFF,
                13'd1, 1'b1};
        rows.push_back(r);
        r.p = '{48'd0, 20'h7FFFF, 16'd0, 18'd0, 18'd0, 16'd0, 1'b1};
        r.b = '{48'd0, 20'h7FFFF, 16'd0, 18'd0, 18'd0, 16'd0, 13'd1, 1'b1};
        rows.push_back(r);
        r.p = '{48'd5, 20'd0, 16'hFFFF, 18'd7, 18'd9, 16'd3, 1'b1};
        r.b = '{48'd5, 20'd0, 16'hFFFF, 18'd7, 18'd9, 16'd3, 13'd1, 1'b1};
        rows.push_back(r);
        r.has_bin = 0;
        // invalid error inside a multi-point bin, earlier point, close plus end
        r.p = '{48'd1000, 20'd100, 16'd50, 18'd10, 18'd20, 16'd30, 1'b0}; rows.push_back(r);
        r.p = '{48'd1100, 20'hFFF00, 16'd0, 18'd11, 18'd21, 16'd31, 1'b0}; rows.push_back(r);
        r.p = '{48'd900, 20'd300, 16'd70, 18'd12, 18'd22, 16'd32, 1'b0}; rows.push_back(r);
        r.p = '{48'd1600, 20'd5, 16'd9, 18'd13, 18'd23, 16'd33, 1'b0}; rows.push_back(r);
        r.p = '{48'd1601, 20'd5, 16'd600, 18'd1, 18'd2, 16'd3, 1'b0}; rows.push_back(r);
        r.p = '{48'd9000, 20'd7, 16'd3, 18'd4, 18'd5, 16'd6, 1'b1}; rows.push_back(r);
        foreach (rows[i]) begin
            send_point(rows[i].p);
            if (rows[i].has_bin && bins_due.size() != 0) bins_due[$] = rows[i].b;
        end
        drain();

        // zero width: only identical times share a bin; other registers at extremes
        write_reg(CfgBinWidth, 27'd0);
        write_reg(CfgDefError, 27'd65535);
        write_reg(CfgNone, 27'h7FFFFFF);
        t = 48'd77;
        for (k = 0; k < 12; k++) begin
            p = rand_point(t, (k == 11) ? 100 : 0);
            if (k % 3 == 2) p.err = 16'd0;
            send_point(p);
            if ($urandom_range(1)) t = t + 1;
        end
        drain();

        for (phase = 0; phase < 6; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            case (phase)
                0: begin write_reg(CfgBinWidth, 27'd600); write_reg(CfgDefError, 27'd1); end
                1: write_reg(CfgBinWidth, 27'd1);
                2: write_reg(CfgBinWidth, 27'd86400000);
                3: begin write_reg(CfgBinWidth, 27'($urandom_range(5000, 1)));
                         write_reg(CfgDefError, 27'($urandom_range(65535, 1))); end
                4: write_reg(CfgBinWidth, 27'd300);
                default: write_reg(CfgBinWidth, 27'h7FFFFFF);
            endcase
            // narrow bins close often, so a long hold-off backs up into the input
            if (phase == 1) hold_off = 3000;
            t = 48'($urandom) | (48'($urandom_range(65535)) << 32);
            for (k = 0; k < 145; k++) begin
                if ($urandom_range(19) == 0) t = t - 48'($urandom_range(50));
                else t = t + 48'($urandom_range(width_q > 400 ? 400 : width_q + 2));
                send_point(rand_point(t, 4));
            end
            send_point(rand_point(t + 1, 100));
            drain();
        end

        if (errors == 0 && bins_due.size() == 0) begin
            $display("PASS time_bin_weighted_average");
        end else begin
            $display("FAIL time_bin_weighted_average");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/tbwa_pkg.sv
rtl/tbwa_div.sv
rtl/tbwa_sqrt.sv
rtl/tbwa_datapath.sv
rtl/tbwa_ctrl.sv
rtl/time_bin_weighted_average.sv
bench/tb_time_bin_weighted_average.sv
